@@ hdl/plt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// plt_pkg
// Shared types and codes for the positional list table: request and result
// beats, request and status codes, and the control word broadcast to the cells.
// ============================================================================
package plt_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int POS_W             = 8;
    localparam int VALUE_W           = 32;

    typedef enum logic [1:0] {
        REQ_GET    = 2'd0,
        REQ_LOCATE = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_DELETE = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_code_t;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]          found_position;
        logic [POS_W-1:0]          list_length;
    } rsp_t;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] count;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/positional_list_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// positional_list_table_top
// Bounded ordered list of signed words addressed by 1-based position:
// get, locate, insert and delete over a chain of slot cells.
// ============================================================================
// Channel   Signals             Handshake
// request   req (req_t)         taken when start is high and busy is low
// result    rsp (rsp_t)         valid for one cycle while done is high
//
// One beat per cycle: a request is registered, executed in the next cycle
// across the cell chain, and its result is registered with done in the cycle
// after that. Busy stays low. The locate and read-out chains ripple through
// all CAPACITY cells in the execute cycle. Reset clears the length; slot
// contents are unknown until written. The receiver cannot stall.
// ============================================================================
module positional_list_table_top
    import plt_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    input  wire       start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EW    = ELEMENT_WIDTH;

    logic             req_valid_reg;
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    cell_ctrl_t       ctrl;
    logic [63:0]      value64;
    logic [EW-1:0]    key;
    logic [63:0]      rd64;
    logic [POS_W:0]   pos9;
    logic [POS_W:0]   count9;
    logic             pos_bad;
    logic             ins_bad;
    logic             full;

    logic [EW-1:0]    data_w  [CAPACITY];
    logic [EW-1:0]    rd_w    [CAPACITY+1];
    logic             found_w [CAPACITY+1];
    logic [POS_W-1:0] fpos_w  [CAPACITY+1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            count_reg     <= count_next;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign value64 = {{32{req_reg.value[VALUE_W-1]}}, req_reg.value};
    assign key     = value64[EW-1:0];
    assign pos9    = {1'b0, req_reg.position};
    assign count9  = (POS_W+1)'(count_reg);
    assign pos_bad = (req_reg.position == '0) || (pos9 > count9);
    assign ins_bad = (req_reg.position == '0) || (pos9 > count9 + 1'b1);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    assign ctrl.ins   = req_valid_reg && (req_reg.req_type == REQ_INSERT) && !ins_bad && !full;
    assign ctrl.del   = req_valid_reg && (req_reg.req_type == REQ_DELETE) && !pos_bad;
    assign ctrl.pos   = req_reg.position;
    assign ctrl.count = POS_W'(count_reg);

    assign rd_w[0]    = '0;
    assign found_w[0] = 1'b0;
    assign fpos_w[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [EW-1:0] prev_d;
            logic [EW-1:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = '0;
            end
            else
            begin : g_mid
                assign prev_d = data_w[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_d = '0;
            end
            else
            begin : g_inner
                assign next_d = data_w[gi+1];
            end
            plt_cell #(
                .CELL_IDX      (gi),
                .ELEMENT_WIDTH (EW)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .key       (key),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (data_w[gi]),
                .found_in  (found_w[gi]),
                .fpos_in   (fpos_w[gi]),
                .rd_in     (rd_w[gi]),
                .found_out (found_w[gi+1]),
                .fpos_out  (fpos_w[gi+1]),
                .rd_out    (rd_w[gi+1])
            );
        end
    endgenerate

    generate
        if (EW >= 64)
        begin : g_rd_full
            assign rd64 = rd_w[CAPACITY];
        end
        else
        begin : g_rd_ext
            assign rd64 = {{(64-EW){rd_w[CAPACITY][EW-1]}}, rd_w[CAPACITY]};
        end
    endgenerate

    always_comb
    begin
        count_next              = count_reg;
        rsp_next.status         = ST_OK;
        rsp_next.read_value     = '0;
        rsp_next.found_position = '0;
        case (req_reg.req_type)
            REQ_GET:
            begin
                if (pos_bad)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    rsp_next.read_value = rd64[VALUE_W-1:0];
                end
            end
            REQ_LOCATE:
            begin
                if (found_w[CAPACITY])
                begin
                    rsp_next.found_position = fpos_w[CAPACITY];
                end
                else
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
            end
            REQ_INSERT:
            begin
                if (ins_bad)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else if (req_valid_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_DELETE:
            begin
                if (pos_bad)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    rsp_next.read_value = rd64[VALUE_W-1:0];
                    if (req_valid_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
        rsp_next.list_length = POS_W'(count_next);
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

@@ hdl/plt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// plt_cell
// One list slot. Loads, shifts from a neighbor or holds; compares against the
// search key and passes the first-match and read-out chains to the next cell.
// ============================================================================
module plt_cell
    import plt_pkg::*;
#(
    parameter int CELL_IDX      = 0,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire                      clk,
    input  wire  cell_ctrl_t         ctrl,
    input  wire  [ELEMENT_WIDTH-1:0] key,
    input  wire  [ELEMENT_WIDTH-1:0] prev_data,
    input  wire  [ELEMENT_WIDTH-1:0] next_data,
    output logic [ELEMENT_WIDTH-1:0] data,
    input  wire                      found_in,
    input  wire  [POS_W-1:0]         fpos_in,
    input  wire  [ELEMENT_WIDTH-1:0] rd_in,
    output logic                     found_out,
    output logic [POS_W-1:0]         fpos_out,
    output logic [ELEMENT_WIDTH-1:0] rd_out
);

    localparam logic [POS_W:0] POS_HERE = (POS_W+1)'(CELL_IDX + 1);

    logic [ELEMENT_WIDTH-1:0] data_reg;
    logic [ELEMENT_WIDTH-1:0] data_next;
    logic                     at_pos;
    logic                     above_pos;
    logic                     live;
    logic                     match;

    assign at_pos    = ({1'b0, ctrl.pos} == POS_HERE);
    assign above_pos = (POS_HERE > {1'b0, ctrl.pos});
    assign live      = (POS_HERE <= {1'b0, ctrl.count});
    assign match     = live && (data_reg == key);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (at_pos)
            begin
                data_next = key;
            end
            else if (above_pos)
            begin
                data_next = prev_data;
            end
        end
        else if (ctrl.del && (at_pos || above_pos))
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign found_out = found_in || match;
    assign fpos_out  = found_in ? fpos_in : (match ? POS_HERE[POS_W-1:0] : '0);
    assign rd_out    = at_pos ? data_reg : rd_in;

endmodule
`default_nettype wire

@@ test/positional_list_table_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// positional_list_table_checker
// Watches the request and result channels of the positional list table,
// keeps its own copy of the list to predict each result, and compares every
// result beat field by field against the oldest prediction.
// ============================================================================
module positional_list_table_checker
    import plt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  start,
    input  wire  busy,
    input  req_t req,
    input  wire  done,
    input  rsp_t rsp,
    output int   errors,
    output int   pending,
    output int   checked
);

    logic signed [VALUE_W-1:0] list_words [CAPACITY];
    int                        list_len;
    rsp_t                      expected_rsp [$];

    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        int   p;
        int   j;
        o = '0;
        o.status = ST_OK;
        p = int'(r.position);
        case (req_code_t'(r.req_type))
            REQ_GET:
                if (p < 1 || p > list_len)
                    o.status = ST_RANGE;
                else
                    o.read_value = list_words[p-1];
            REQ_LOCATE:
            begin
                o.status = ST_NOTFOUND;
                for (j = 0; j < list_len; j++)
                begin
                    if (o.status == ST_NOTFOUND && list_words[j] == r.value)
                    begin
                        o.status         = ST_OK;
                        o.found_position = POS_W'(j + 1);
                    end
                end
            end
            REQ_INSERT:
                if (p < 1 || p > list_len + 1)
                    o.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    for (j = list_len; j >= p; j--)
                        list_words[j] = list_words[j-1];
                    list_words[p-1] = r.value;
                    list_len++;
                end
            default:
                if (p < 1 || p > list_len)
                    o.status = ST_RANGE;
                else
                begin
                    o.read_value = list_words[p-1];
                    for (j = p; j < list_len; j++)
                        list_words[j-1] = list_words[j];
                    list_len--;
                end
        endcase
        o.list_length = POS_W'(list_len);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            list_len = 0;
            expected_rsp.delete();
            errors  <= 0;
            checked <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (errors < 10)
                        $display("[%0t] result beat with nothing expected: st=%0d rd=%0d fp=%0d len=%0d",
                                 $realtime, rsp.status, rsp.read_value, rsp.found_position,
                                 rsp.list_length);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.read_value !== want.read_value
                        || rsp.found_position !== want.found_position
                        || rsp.list_length !== want.list_length)
                    begin
                        if (errors < 10)
                            $display("[%0t] result %0d: expected st=%0d rd=%0d fp=%0d len=%0d, got st=%0d rd=%0d fp=%0d len=%0d",
                                     $realtime, checked, want.status, want.read_value,
                                     want.found_position, want.list_length, rsp.status,
                                     rsp.read_value, rsp.found_position, rsp.list_length);
                        errors <= errors + 1;
                    end
                    checked <= checked + 1;
                end
            end
            if (start && !busy)
                expected_rsp.push_back(apply_request(req));
            pending <= expected_rsp.size();
        end
    end

endmodule

@@ test/positional_list_table_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// positional_list_table_top_tb
// Drives get, locate, insert and delete requests into the positional list
// table: a directed set over the edge cases, then random runs that grow and
// shrink the list between empty and full, with random idle gaps. A checker
// beside the block predicts and compares every result beat.
// ============================================================================
module positional_list_table_top_tb;
    import plt_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int   errors;
    int   pending;
    int   checked;
    int   op_count [4];

    logic signed [VALUE_W-1:0] value_pool [8];

    positional_list_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    positional_list_table_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap(bit gaps_on);
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return value_pool[$urandom_range(0, 7)];
        if (roll < 55)
            return roll[0] ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return POS_W'($urandom_range(0, 255));
        if (roll < 50)
            return POS_W'($urandom_range(1, 2));
        return POS_W'($urandom_range(0, CAPACITY_DEF + 1));
    endfunction

    task automatic send(req_code_t code, logic [POS_W-1:0] pos,
                        logic signed [VALUE_W-1:0] val, int gap);
        logic held;
        start        <= 1'b1;
        req.req_type <= code;
        req.position <= pos;
        req.value    <= val;
        forever
        begin
            @(negedge clk);
            held = busy;
            @(posedge clk);
            if (!held)
                break;
        end
        op_count[code]++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int        chunk;
        int        n;
        int        roll;
        int        mode;
        int        waited;
        bit        gaps_on;
        req_code_t code;

        value_pool = '{32'sd0, -32'sd1, 32'sh80000000, 32'sh7fffffff,
                       32'sd5, 32'sd1234, -32'sd77, 32'sh55aa55aa};
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(REQ_GET,    8'd1,   32'sd0,        0);
        send(REQ_DELETE, 8'd1,   32'sd0,        1);
        send(REQ_LOCATE, 8'd0,   32'sd0,        0);
        send(REQ_INSERT, 8'd0,   32'sd9,        0);
        send(REQ_INSERT, 8'd2,   32'sd9,        2);
        send(REQ_INSERT, 8'd1,   32'sh80000000, 0);
        send(REQ_INSERT, 8'd2,   32'sh7fffffff, 0);
        send(REQ_INSERT, 8'd2,   -32'sd1,       0);
        send(REQ_INSERT, 8'd1,   32'sd5,        1);
        send(REQ_INSERT, 8'd5,   32'sd5,        0);
        send(REQ_LOCATE, 8'd3,   32'sd5,        0);
        send(REQ_LOCATE, 8'd0,   32'sh7fffffff, 0);
        send(REQ_LOCATE, 8'd1,   32'sd1234,     3);
        send(REQ_GET,    8'd5,   32'sd0,        0);
        send(REQ_GET,    8'd6,   32'sd0,        0);
        send(REQ_GET,    8'd255, 32'shffffffff, 0);
        send(REQ_GET,    8'd0,   32'sd0,        0);
        send(REQ_DELETE, 8'd3,   32'sd0,        0);
        send(REQ_DELETE, 8'd255, 32'sd0,        1);
        send(REQ_DELETE, 8'd1,   32'sd0,        0);
        send(REQ_INSERT, 8'd255, 32'sd3,        0);
        send(REQ_LOCATE, 8'd255, 32'sh80000000, 0);
        send(REQ_INSERT, 8'd4,   32'sh55aa55aa, 0);
        send(REQ_GET,    8'd4,   32'sd0,        0);
        drain();

        for (chunk = 0; chunk < 12; chunk++)
        begin
            mode    = (chunk % 3 == 0) ? 0 : $urandom_range(0, 2);
            gaps_on = (chunk % 4 != 1);
            for (n = 0; n < 50; n++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       code = roll < 60 ? REQ_INSERT : roll < 70 ? REQ_DELETE
                                  : roll < 85 ? REQ_GET : REQ_LOCATE;
                    1:       code = roll < 60 ? REQ_DELETE : roll < 70 ? REQ_INSERT
                                  : roll < 85 ? REQ_GET : REQ_LOCATE;
                    default: code = req_code_t'(roll % 4);
                endcase
                send(code, pick_position(), pick_value(), pick_gap(gaps_on));
            end
            if (chunk % 4 == 2)
                drain();
        end

        start <= 1'b0;
        waited = 0;
        @(negedge clk);
        while (pending != 0 && waited < 1000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);

        $display("requests: %0d get, %0d locate, %0d insert, %0d delete",
                 op_count[REQ_GET], op_count[REQ_LOCATE], op_count[REQ_INSERT],
                 op_count[REQ_DELETE]);
        $display("result beats compared: %0d, outstanding: %0d, mismatches: %0d",
                 checked, pending, errors);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hdl/plt_pkg.sv
hdl/plt_cell.sv
hdl/positional_list_table_top.sv
test/positional_list_table_checker.sv
test/positional_list_table_top_tb.sv
